>>> rtl/sgfmsp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SGF move sequence parser package
// Shared types, character codes and result codes for the move parser.
// ---------------------------------------------------------------------------
package sgfmsp_pkg;

   typedef enum logic [2:0] {
      PH_SEP          = 3'd0,
      PH_COLOUR       = 3'd1,
      PH_OPEN         = 3'd2,
      PH_VALUE        = 3'd3,
      PH_STOP_FORMAT  = 3'd4,
      PH_STOP_PLAYER  = 3'd5,
      PH_STOP_COORD   = 3'd6
   } phase_type;

   typedef struct packed {
      logic        item_kind;
      logic [11:0] move_index;
      logic [1:0]  final_status;
   } rsp_item_type;

   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_OPEN  = 8'h5B;
   localparam logic [7:0] CHAR_CLOSE = 8'h5D;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_W     = 8'h57;
   localparam logic [7:0] CHAR_T     = 8'h74;
   localparam logic [7:0] CHAR_UC_A  = 8'h41;
   localparam logic [7:0] CHAR_UC_Z  = 8'h5A;

   localparam logic [5:0] BOARD_SIZE_RESET = 6'd19;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FORMAT = 2'd1;
   localparam logic [1:0] ST_PLAYER = 2'd2;
   localparam logic [1:0] ST_COORD  = 2'd3;

   localparam logic KIND_MOVE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Upper-case letters map to 26..51, everything else uses the lower-case rule.
   function automatic logic signed [8:0] letter_value(input logic [7:0] c);
      logic signed [8:0] wide;
      wide = $signed({1'b0, c});
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         return wide - 9'sd39;
      end
      return wide - 9'sd97;
   endfunction

endpackage

>>> rtl/sgf_move_sequence_parser.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SGF move sequence parser
// Parses a compact move record byte by byte and queues move and status
// results in a four-entry result queue.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid/req_stall  | text_byte, end_of_text
//  rsp     | out       | rsp_valid/rsp_stall  | item_kind, move_index,
//          |           |                      | final_status, last_result
//  csr     | in        | csr_write_enable     | board_size
//
//  One byte is taken per cycle while req_stall is low; it is parsed in the
//  cycle of its transaction and its results are registered into the queue.
//  A byte yields up to two results; the result queue holds four, so the
//  input stalls while more than two entries are occupied.
//  Reset is synchronous and clears the parser, the queue and sets the board
//  size to 19. A stalled result transaction holds its payload.
// ---------------------------------------------------------------------------
module sgf_move_sequence_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_item_kind,
   output logic [11:0] rsp_move_index,
   output logic [1:0]  rsp_final_status,
   output logic        rsp_last_result,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data
);
   import sgfmsp_pkg::*;

   logic [5:0]   board_size_ff;
   phase_type    phase_ff, phase_in;
   logic         black_to_move_ff, black_to_move_in;
   logic [1:0]   value_length_ff, value_length_in;
   logic [7:0]   first_char_ff, first_char_in;
   logic [7:0]   second_char_ff, second_char_in;

   rsp_item_type fifo_ff [4];
   logic [1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [2:0]   count_ff;

   logic              req_accept, rsp_accept;
   logic              move_push;
   logic [1:0]        status_code;
   logic              is_pass, legal;
   logic signed [9:0] col_s, row_s, bs_s;
   logic [5:0]        mul_a, mul_add;
   logic [11:0]       move_idx;
   rsp_item_type      move_item, status_item, first_item;
   logic [1:0]        push_count;

   assign req_stall  = (count_ff > 3'd2);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != 3'd0);
   assign rsp_accept = rsp_valid && !rsp_stall;

   // Coordinate decode of the current value; pass and move share one multiplier.
   always_comb begin
      is_pass = (value_length_ff == 2'd0) ||
                (value_length_ff == 2'd2 && first_char_ff == CHAR_T &&
                 second_char_ff == CHAR_T);
      bs_s  = $signed({4'b0000, board_size_ff});
      col_s = 10'(letter_value(first_char_ff));
      row_s = bs_s - 10'(letter_value(second_char_ff)) - 10'sd1;
      legal = is_pass || (value_length_ff != 2'd1 && col_s >= 10'sd0 && col_s < bs_s &&
                          row_s >= 10'sd0 && row_s < bs_s);
      mul_a   = is_pass ? board_size_ff : row_s[5:0];
      mul_add = is_pass ? 6'd0 : col_s[5:0];
      move_idx = ({6'd0, mul_a} * {6'd0, board_size_ff}) + {6'd0, mul_add};
   end

   always_comb begin
      phase_in         = phase_ff;
      black_to_move_in = black_to_move_ff;
      value_length_in  = value_length_ff;
      first_char_in    = first_char_ff;
      second_char_in   = second_char_ff;
      move_push        = 1'b0;
      unique case (phase_ff)
         PH_SEP: begin
            phase_in = (req_text_byte == CHAR_SEMI) ? PH_COLOUR : PH_STOP_FORMAT;
         end
         PH_COLOUR: begin
            if (req_text_byte == (black_to_move_ff ? CHAR_B : CHAR_W)) begin
               phase_in = PH_OPEN;
            end else begin
               phase_in = PH_STOP_PLAYER;
            end
         end
         PH_OPEN: begin
            if (req_text_byte == CHAR_OPEN) begin
               phase_in        = PH_VALUE;
               value_length_in = 2'd0;
               first_char_in   = 8'd0;
               second_char_in  = 8'd0;
            end else begin
               phase_in = PH_STOP_FORMAT;
            end
         end
         PH_VALUE: begin
            if (req_text_byte == CHAR_CLOSE) begin
               if (legal) begin
                  move_push        = 1'b1;
                  black_to_move_in = !black_to_move_ff;
                  phase_in         = PH_SEP;
               end else begin
                  phase_in = PH_STOP_COORD;
               end
            end else begin
               if (value_length_ff == 2'd0) begin
                  first_char_in = req_text_byte;
               end else if (value_length_ff == 2'd1) begin
                  second_char_in = req_text_byte;
               end
               if (value_length_ff != 2'd3) begin
                  value_length_in = value_length_ff + 2'd1;
               end
            end
         end
         default: ;
      endcase

      unique case (phase_in)
         PH_SEP:                       status_code = ST_OK;
         PH_COLOUR, PH_STOP_PLAYER:    status_code = ST_PLAYER;
         PH_STOP_COORD:                status_code = ST_COORD;
         default:                      status_code = ST_FORMAT;
      endcase

      if (req_end_of_text) begin
         phase_in         = PH_SEP;
         black_to_move_in = 1'b1;
         value_length_in  = 2'd0;
         first_char_in    = 8'd0;
         second_char_in   = 8'd0;
      end

      move_item.item_kind      = KIND_MOVE;
      move_item.move_index     = move_idx;
      move_item.final_status   = ST_OK;
      status_item.item_kind    = KIND_STATUS;
      status_item.move_index   = 12'd0;
      status_item.final_status = status_code;
      first_item = move_push ? move_item : status_item;
      push_count = req_accept ? ({1'b0, move_push} + {1'b0, req_end_of_text}) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff    <= BOARD_SIZE_RESET;
         phase_ff         <= PH_SEP;
         black_to_move_ff <= 1'b1;
         value_length_ff  <= 2'd0;
         first_char_ff    <= 8'd0;
         second_char_ff   <= 8'd0;
         wr_ptr_ff        <= 2'd0;
         rd_ptr_ff        <= 2'd0;
         count_ff         <= 3'd0;
      end else begin
         if (csr_write_enable) begin
            board_size_ff <= csr_write_data;
         end
         if (req_accept) begin
            phase_ff         <= phase_in;
            black_to_move_ff <= black_to_move_in;
            value_length_ff  <= value_length_in;
            first_char_ff    <= first_char_in;
            second_char_ff   <= second_char_in;
         end
         wr_ptr_ff <= wr_ptr_ff + push_count;
         rd_ptr_ff <= rd_ptr_ff + {1'b0, rsp_accept};
         count_ff  <= count_ff + {1'b0, push_count} - {2'b00, rsp_accept};
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= first_item;
      end
      if (push_count == 2'd2) begin
         fifo_ff[wr_ptr_ff + 2'd1] <= status_item;
      end
   end

   assign rsp_item_kind    = fifo_ff[rd_ptr_ff].item_kind;
   assign rsp_move_index   = fifo_ff[rd_ptr_ff].move_index;
   assign rsp_final_status = fifo_ff[rd_ptr_ff].final_status;
   assign rsp_last_result  = fifo_ff[rd_ptr_ff].item_kind;

   // The result queue never holds more than its four entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overflow");

   // The last byte of a sequence always leaves a status result queued.
   a_status_queued: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_end_of_text |=> count_ff != 3'd0)
      else $error("status result missing after end of text");

   // The last byte of a sequence returns the parser to its start.
   a_parse_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_end_of_text |=> phase_ff == PH_SEP && black_to_move_ff &&
                                        value_length_ff == 2'd0)
      else $error("parser not restarted after end of text");

   // The colour to move changes only with a move result or a restart.
   a_colour_change: assert property (@(posedge clock) disable iff (reset)
      req_accept && !move_push && !req_end_of_text |=> $stable(black_to_move_ff))
      else $error("colour changed without a move");

endmodule

>>> verif/sgfmsp_parse_monitor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Move parser transaction monitor
// Watches the byte, result and register ports of the move sequence parser,
// keeps its own copy of the parse state to work out the move and status
// transactions that each accepted byte must produce, and compares every
// result transaction field by field with the oldest one still owed.
// ---------------------------------------------------------------------------
module sgfmsp_parse_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_item_kind,
   input  logic [11:0] rsp_move_index,
   input  logic [1:0]  rsp_final_status,
   input  logic        rsp_last_result,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data,
   output int          error_count,
   output int          pending_count,
   output int          move_count,
   output int          status_count
);
   import sgfmsp_pkg::*;

   localparam logic [7:0] CHAR_LC_A = 8'h61;

   typedef struct {
      logic        item_kind;
      logic [11:0] move_index;
      logic [1:0]  final_status;
      logic        last_result;
   } parse_result_type;

   parse_result_type parse_results_q [$];
   phase_type        phase;
   logic             black_to_move;
   logic [1:0]       value_length;
   logic [7:0]       first_char;
   logic [7:0]       second_char;
   logic [5:0]       board_size;

   function automatic int letter_code(input logic [7:0] c);
      if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
         return int'(c - CHAR_UC_A) + 26;
      end
      return int'(c) - int'(CHAR_LC_A);
   endfunction

   task automatic restart_game();
      phase = PH_SEP;
      black_to_move = 1'b1;
      value_length = 2'd0;
      first_char = 8'd0;
      second_char = 8'd0;
   endtask

   task automatic parse_byte(input logic [7:0] text, input logic last);
      int               size;
      int               col;
      int               row;
      bit               legal;
      logic [11:0]      index;
      logic [1:0]       status;
      parse_result_type result_item;
      size = int'(board_size);
      index = 12'd0;
      case (phase)
         PH_SEP: begin
            phase = (text == CHAR_SEMI) ? PH_COLOUR : PH_STOP_FORMAT;
         end
         PH_COLOUR: begin
            phase = (text == (black_to_move ? CHAR_B : CHAR_W)) ? PH_OPEN : PH_STOP_PLAYER;
         end
         PH_OPEN: begin
            if (text == CHAR_OPEN) begin
               phase = PH_VALUE;
               value_length = 2'd0;
               first_char = 8'd0;
               second_char = 8'd0;
            end else begin
               phase = PH_STOP_FORMAT;
            end
         end
         PH_VALUE: begin
            if (text == CHAR_CLOSE) begin
               legal = 1'b1;
               if (value_length == 2'd0 || (value_length == 2'd2 &&
                   first_char == CHAR_T && second_char == CHAR_T)) begin
                  index = 12'(size * size);
               end else if (value_length == 2'd1) begin
                  legal = 1'b0;
               end else begin
                  col = letter_code(first_char);
                  row = size - letter_code(second_char) - 1;
                  legal = col >= 0 && col < size && row >= 0 && row < size;
                  index = 12'(row * size + col);
               end
               if (legal) begin
                  result_item = '{KIND_MOVE, index, ST_OK, 1'b0};
                  parse_results_q.insert(parse_results_q.size(), result_item);
                  move_count++;
                  black_to_move = !black_to_move;
                  phase = PH_SEP;
               end else begin
                  phase = PH_STOP_COORD;
               end
            end else begin
               if (value_length == 2'd0) begin
                  first_char = text;
               end else if (value_length == 2'd1) begin
                  second_char = text;
               end
               if (value_length != 2'd3) begin
                  value_length = value_length + 2'd1;
               end
            end
         end
         default: begin
         end
      endcase

      if (last) begin
         case (phase)
            PH_SEP: begin
               status = ST_OK;
            end
            PH_COLOUR, PH_STOP_PLAYER: begin
               status = ST_PLAYER;
            end
            PH_STOP_COORD: begin
               status = ST_COORD;
            end
            default: begin
               status = ST_FORMAT;
            end
         endcase
         result_item = '{KIND_STATUS, 12'd0, status, 1'b1};
         parse_results_q.insert(parse_results_q.size(), result_item);
         status_count++;
         restart_game();
      end
   endtask

   task automatic compare_field(input string name, input logic [11:0] want,
                                input logic [11:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_result();
      parse_result_type want;
      if (parse_results_q.size() == 0) begin
         $error("result transaction with none owed: item_kind %0d move_index %0d status %0d",
                rsp_item_kind, rsp_move_index, rsp_final_status);
         error_count++;
         return;
      end
      want = parse_results_q.pop_front();
      compare_field("item_kind", 12'(want.item_kind), 12'(rsp_item_kind));
      compare_field("move_index", want.move_index, rsp_move_index);
      compare_field("final_status", 12'(want.final_status), 12'(rsp_final_status));
      compare_field("last_result", 12'(want.last_result), 12'(rsp_last_result));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restart_game();
         board_size = BOARD_SIZE_RESET;
         parse_results_q.delete();
         error_count = 0;
         move_count = 0;
         status_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         if (req_valid && !req_stall) begin
            parse_byte(req_text_byte, req_end_of_text);
         end
         if (csr_write_enable) begin
            board_size = csr_write_data;
         end
      end
      pending_count <= parse_results_q.size();
   end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Move sequence parser testbench
// Feeds the parser a short set of hand-written move records and then
// randomly built records, mostly well formed with random coordinates and
// some broken or pure noise, across a range of board sizes. Both sides idle
// at random, and the result side is once held off long enough to fill the
// parser. A separate monitor predicts and compares every transaction.
// ---------------------------------------------------------------------------
module tb_top;
   import sgfmsp_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_BYTES = 220;
   localparam int PHASE_COUNT = 9;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_item_kind;
   logic [11:0] rsp_move_index;
   logic [1:0]  rsp_final_status;
   logic        rsp_last_result;
   logic        csr_write_enable = 1'b0;
   logic [5:0]  csr_write_data = 6'd0;

   int          error_count;
   int          pending_count;
   int          move_count;
   int          status_count;
   int          idle_cycles = 0;
   int          byte_total = 0;
   int          seq_total = 0;
   bit          idle_allowed = 1'b1;
   bit          tx_idling = 1'b1;
   bit          rx_idling = 1'b1;
   bit          hold_request = 1'b0;
   bit          black_turn;
   logic [5:0]  board_size = BOARD_SIZE_RESET;
   logic [5:0]  board_plan [PHASE_COUNT] = '{6'd1, 6'd52, 6'd0, 6'd63, 6'd9, 6'd25,
                                             6'd13, 6'd40, 6'd19};
   logic [7:0]  text_q [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sgf_move_sequence_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_move_index   (rsp_move_index),
      .rsp_final_status (rsp_final_status),
      .rsp_last_result  (rsp_last_result),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   sgfmsp_parse_monitor parse_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_move_index   (rsp_move_index),
      .rsp_final_status (rsp_final_status),
      .rsp_last_result  (rsp_last_result),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .pending_count    (pending_count),
      .move_count       (move_count),
      .status_count     (status_count)
   );

   function automatic logic [7:0] coord_letter(input int v);
      if (v < 26) begin
         return 8'h61 + 8'(v);
      end
      return CHAR_UC_A + 8'(v - 26);
   endfunction

   function automatic int pick_coord();
      int span;
      span = (board_size > 6'd52) ? 52 : int'(board_size);
      if (span == 0 || $urandom_range(0, 7) == 0) begin
         return $urandom_range(0, 51);
      end
      return $urandom_range(0, span - 1);
   endfunction

   task automatic append_byte(input logic [7:0] b);
      text_q.insert(text_q.size(), b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         append_byte(s[i]);
      end
   endtask

   task automatic push_value();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0: begin
         end
         1: begin
            append_byte(CHAR_T);
            append_byte(CHAR_T);
         end
         2: begin
            append_byte(coord_letter(pick_coord()));
         end
         3: begin
            append_byte(CHAR_T);
            append_byte(CHAR_T);
            repeat ($urandom_range(1, 3)) append_byte(coord_letter(pick_coord()));
         end
         4: begin
            repeat ($urandom_range(3, 5)) append_byte(coord_letter(pick_coord()));
         end
         5: begin
            repeat (2) append_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            append_byte(coord_letter(pick_coord()));
            append_byte(coord_letter(pick_coord()));
         end
      endcase
   endtask

   // Most records are well formed; a few are corrupted, cut short, start
   // with the wrong colour or are plain noise.
   task automatic build_game();
      int style;
      int cut;
      style = $urandom_range(0, 19);
      if (style < 2) begin
         repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
         return;
      end
      black_turn = 1'b1;
      repeat ($urandom_range(1, 6)) begin
         append_byte(CHAR_SEMI);
         append_byte(black_turn ? CHAR_B : CHAR_W);
         append_byte(CHAR_OPEN);
         push_value();
         append_byte(CHAR_CLOSE);
         black_turn = !black_turn;
      end
      if (style == 2) begin
         text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (style == 3) begin
         cut = $urandom_range(1, text_q.size() - 1);
         while (text_q.size() > cut) begin
            void'(text_q.pop_back());
         end
      end else if (style == 4) begin
         text_q[1] = CHAR_W;
      end
   endtask

   task automatic send_text();
      int gap;
      for (int i = 0; i < text_q.size(); i++) begin
         if (tx_idling && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         req_valid <= 1'b1;
         req_text_byte <= text_q[i];
         req_end_of_text <= (i == text_q.size() - 1);
         do @(posedge clock); while (req_stall);
      end
      byte_total += text_q.size();
      seq_total++;
      text_q.delete();
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      req_end_of_text <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // Result side: random stall bursts, quiet stretches and one long hold-off.
   initial begin
      int span;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (rx_idling && $urandom_range(0, 15) == 0) begin
            span = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (span - 1) @(negedge clock);
         end else begin
            span = (rx_idling && $urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : 1;
            rsp_stall <= 1'b0;
            repeat (span - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d result transactions still owed.", pending_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      string directed [7];
      int    phase_bytes;
      directed = '{";B[tt];W[]", ";B[ttt]", ";W", ";", "x", ";B[a]", ";B"};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         push_text(directed[i]);
         send_text();
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         idle_allowed = (p != PHASE_COUNT - 1);
         rx_idling = idle_allowed;
         drain();
         board_size = (p == 5) ? 6'($urandom_range(2, 51)) : board_plan[p];
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data <= board_size;
         @(negedge clock);
         csr_write_enable <= 1'b0;
         if (p == 1) begin
            hold_request = 1'b1;
         end
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            build_game();
            phase_bytes += text_q.size();
            tx_idling = idle_allowed && ($urandom_range(0, 3) != 0);
            send_text();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d text bytes in %0d records over nine board sizes, 0, 1, 52 and 63 too.",
               byte_total, seq_total);
      $display("Checked %0d move and %0d status transactions, one %0d-cycle result hold-off.",
               move_count, status_count, HOLD_CYCLES);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/sgfmsp_pkg.sv
rtl/sgf_move_sequence_parser.sv
verif/sgfmsp_parse_monitor.sv
verif/tb_top.sv
